// ----- src/sprite_rle_decoder_defines.svh -----
// Assertion macros shared by the sprite decoder checker.
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SRD_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("sprite decoder assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SRD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("sprite decoder assertion failed");

`endif

// ----- src/srd_pkg.sv -----
// Shared types and constants of the sprite run-length decoder.
package srd_pkg;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Command kinds handed from the front to the back.
    localparam logic OP_RUN     = 1'b0;  // count words at consecutive addresses
    localparam logic OP_LIT_ERR = 1'b1;  // one pixel, then a bounds error

    localparam int CNT_W         = 7;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             op;
        logic [1:0]       kind;
        logic [15:0]      addr;
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
        logic             sprite_end;
        logic [7:0]       width;
        logic [7:0]       height;
        logic [7:0]       offset_x;
        logic [7:0]       offset_y;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_address;
        logic [7:0]  pixel_value;
        logic [7:0]  sprite_width;
        logic [7:0]  sprite_height;
        logic [7:0]  offset_x;
        logic [7:0]  offset_y;
        logic        sprite_end;
        logic        last;
    } t_result;

endpackage

// ----- src/srd_front.sv -----
// Front end: parses the byte stream, tracks the cursor and queues commands.
module srd_front #(
    parameter int LENGTH_BITS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_in_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output srd_pkg::t_cmd o_cmd
);
    import srd_pkg::*;

    localparam int LEN_W = LENGTH_BITS + 1;

    localparam logic [2:0] PH_W    = 3'd0;
    localparam logic [2:0] PH_H    = 3'd1;
    localparam logic [2:0] PH_X    = 3'd2;
    localparam logic [2:0] PH_Y    = 3'd3;
    localparam logic [2:0] PH_ROWS = 3'd4;
    localparam logic [2:0] PH_SPEC = 3'd5;
    localparam logic [2:0] PH_LIT  = 3'd6;
    localparam logic [2:0] PH_FILL = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_width, n_width;
    logic [7:0]       r_height, n_height;
    logic [7:0]       r_offx, n_offx;
    logic [15:0]      r_limit, n_limit;
    logic [7:0]       r_row_idx, n_row_idx;
    logic [15:0]      r_row_base, n_row_base;
    logic [16:0]      r_cursor, n_cursor;
    logic [7:0]       r_runs_left, n_runs_left;
    logic [CNT_W-1:0] r_lit_left, n_lit_left;
    logic [CNT_W-1:0] r_fill_len, n_fill_len;

    logic             accept;
    logic [LEN_W-1:0] spec_len;
    logic [CNT_W-1:0] spec_cnt;
    logic [7:0]       row_next;
    logic [15:0]      base_next;
    logic             row_done;
    logic [7:0]       runs_next;
    logic [16:0]      cursor_inc;
    logic [CNT_W-1:0] lit_next;
    logic             do_end_row;
    logic             do_abandon;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign spec_len   = LEN_W'(i_in_byte[LENGTH_BITS-1:0]) + LEN_W'(1);
    assign spec_cnt   = CNT_W'(spec_len);
    assign row_next   = r_row_idx + 8'd1;
    assign base_next  = r_row_base + {8'd0, r_width};
    assign row_done   = row_next >= r_height;
    assign runs_next  = r_runs_left - 8'd1;
    assign cursor_inc = r_cursor + 17'd1;
    assign lit_next   = r_lit_left - CNT_W'(1);

    always_comb begin
        n_phase     = r_phase;
        n_width     = r_width;
        n_height    = r_height;
        n_offx      = r_offx;
        n_limit     = r_limit;
        n_row_idx   = r_row_idx;
        n_row_base  = r_row_base;
        n_cursor    = r_cursor;
        n_runs_left = r_runs_left;
        n_lit_left  = r_lit_left;
        n_fill_len  = r_fill_len;
        do_end_row  = 1'b0;
        do_abandon  = 1'b0;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = OP_RUN;
        o_cmd.count = CNT_W'(1);

        if (accept) begin
            case (r_phase)
                PH_W: begin
                    n_width = i_in_byte;
                    n_phase = PH_H;
                end
                PH_H: begin
                    n_height = i_in_byte;
                    n_phase  = PH_X;
                end
                PH_X: begin
                    n_offx  = i_in_byte;
                    n_phase = PH_Y;
                end
                PH_Y: begin
                    n_limit          = 16'(r_width) * 16'(r_height);
                    o_push           = 1'b1;
                    o_cmd.kind       = KIND_HEADER;
                    o_cmd.width      = r_width;
                    o_cmd.height     = r_height;
                    o_cmd.offset_x   = r_offx;
                    o_cmd.offset_y   = i_in_byte;
                    o_cmd.sprite_end = (r_height == 8'd0);
                    n_row_idx        = 8'd0;
                    n_row_base       = 16'd0;
                    n_cursor         = 17'd0;
                    if (r_height == 8'd0) begin
                        do_abandon = 1'b1;
                    end else begin
                        n_phase = PH_ROWS;
                    end
                end
                PH_ROWS: begin
                    n_runs_left = i_in_byte;
                    if (i_in_byte == 8'd0) begin
                        do_end_row = 1'b1;
                        if (row_done) begin
                            o_push           = 1'b1;
                            o_cmd.kind       = KIND_END;
                            o_cmd.sprite_end = 1'b1;
                        end
                    end else begin
                        n_phase = PH_SPEC;
                    end
                end
                PH_SPEC: begin
                    if (i_in_byte[7:6] == 2'd0) begin
                        // skip: cursor may pass the limit, nothing is written
                        n_cursor    = r_cursor + 17'(spec_len);
                        n_runs_left = runs_next;
                        if (runs_next == 8'd0) begin
                            do_end_row = 1'b1;
                            if (row_done) begin
                                o_push           = 1'b1;
                                o_cmd.kind       = KIND_END;
                                o_cmd.sprite_end = 1'b1;
                            end
                        end else begin
                            n_phase = PH_SPEC;
                        end
                    end else if (i_in_byte[7:6] == 2'd1) begin
                        if (r_cursor >= {1'b0, r_limit}) begin
                            o_push     = 1'b1;
                            o_cmd.kind = KIND_ERROR;
                            do_abandon = 1'b1;
                        end else begin
                            n_lit_left = spec_cnt;
                            n_phase    = PH_LIT;
                        end
                    end else begin
                        if ((18'(r_cursor) + 18'(spec_len)) > 18'(r_limit)) begin
                            o_push     = 1'b1;
                            o_cmd.kind = KIND_ERROR;
                            do_abandon = 1'b1;
                        end else begin
                            n_fill_len = spec_cnt;
                            n_phase    = PH_FILL;
                        end
                    end
                end
                PH_LIT: begin
                    o_push      = 1'b1;
                    o_cmd.kind  = KIND_PIXEL;
                    o_cmd.addr  = r_cursor[15:0];
                    o_cmd.value = i_in_byte;
                    n_cursor    = cursor_inc;
                    n_lit_left  = lit_next;
                    if (lit_next == CNT_W'(0)) begin
                        n_runs_left = runs_next;
                        if (runs_next == 8'd0) begin
                            do_end_row       = 1'b1;
                            o_cmd.sprite_end = row_done;
                        end else begin
                            n_phase = PH_SPEC;
                        end
                    end else if (cursor_inc >= {1'b0, r_limit}) begin
                        o_cmd.op   = OP_LIT_ERR;
                        do_abandon = 1'b1;
                    end
                end
                default: begin
                    // fill: the back end expands the run
                    o_push      = 1'b1;
                    o_cmd.kind  = KIND_PIXEL;
                    o_cmd.addr  = r_cursor[15:0];
                    o_cmd.value = i_in_byte;
                    o_cmd.count = r_fill_len;
                    n_cursor    = r_cursor + 17'(r_fill_len);
                    n_fill_len  = CNT_W'(0);
                    n_runs_left = runs_next;
                    if (runs_next == 8'd0) begin
                        do_end_row       = 1'b1;
                        o_cmd.sprite_end = row_done;
                    end else begin
                        n_phase = PH_SPEC;
                    end
                end
            endcase
        end

        if (do_end_row) begin
            n_row_idx  = row_next;
            n_row_base = base_next;
            n_cursor   = {1'b0, base_next};
            if (row_done) begin
                do_abandon = 1'b1;
            end else begin
                n_phase = PH_ROWS;
            end
        end

        if (do_abandon) begin
            n_phase     = PH_W;
            n_row_idx   = 8'd0;
            n_row_base  = 16'd0;
            n_cursor    = 17'd0;
            n_runs_left = 8'd0;
            n_lit_left  = CNT_W'(0);
            n_fill_len  = CNT_W'(0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_W;
            r_width     <= 8'd0;
            r_height    <= 8'd0;
            r_offx      <= 8'd0;
            r_limit     <= 16'd0;
            r_row_idx   <= 8'd0;
            r_row_base  <= 16'd0;
            r_cursor    <= 17'd0;
            r_runs_left <= 8'd0;
            r_lit_left  <= CNT_W'(0);
            r_fill_len  <= CNT_W'(0);
        end else begin
            r_phase     <= n_phase;
            r_width     <= n_width;
            r_height    <= n_height;
            r_offx      <= n_offx;
            r_limit     <= n_limit;
            r_row_idx   <= n_row_idx;
            r_row_base  <= n_row_base;
            r_cursor    <= n_cursor;
            r_runs_left <= n_runs_left;
            r_lit_left  <= n_lit_left;
            r_fill_len  <= n_fill_len;
        end
    end

endmodule

// ----- src/srd_queue.sv -----
// Small command queue between the front and back ends.
module srd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srd_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output srd_pkg::t_cmd o_pop_cmd,
    output logic          o_empty
);
    import srd_pkg::*;

    t_cmd                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [QUEUE_COUNT_W-1:0] r_count;

    localparam logic [QUEUE_PTR_W-1:0]   PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_COUNT_W-1:0] COUNT_FULL = QUEUE_COUNT_W'(QUEUE_DEPTH);

    assign o_full    = (r_count == COUNT_FULL);
    assign o_empty   = (r_count == QUEUE_COUNT_W'(0));
    assign o_pop_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_COUNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_COUNT_W'(1);
            end
        end
    end

endmodule

// ----- src/srd_back.sv -----
// Back end: expands queued commands into result words behind an output register.
module srd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    output logic             o_pop,
    input  srd_pkg::t_cmd    i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output srd_pkg::t_result o_res
);
    import srd_pkg::*;

    t_cmd    r_cmd;
    logic    r_act;
    logic    r_step;
    logic    r_out_valid;
    t_result r_res;

    logic    out_free;
    logic    produce;
    logic    done;
    t_result res;

    assign out_free    = !r_out_valid || i_out_ready;
    assign produce     = r_act && out_free;
    assign o_pop       = !r_act && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        res  = '0;
        done = 1'b0;
        case (r_cmd.op)
            OP_RUN: begin
                res.kind          = r_cmd.kind;
                res.pixel_address = r_cmd.addr;
                res.pixel_value   = r_cmd.value;
                res.sprite_width  = r_cmd.width;
                res.sprite_height = r_cmd.height;
                res.offset_x      = r_cmd.offset_x;
                res.offset_y      = r_cmd.offset_y;
                res.last          = (r_cmd.count == CNT_W'(1));
                res.sprite_end    = res.last && r_cmd.sprite_end;
                done              = res.last;
            end
            OP_LIT_ERR: begin
                if (!r_step) begin
                    res.kind          = KIND_PIXEL;
                    res.pixel_address = r_cmd.addr;
                    res.pixel_value   = r_cmd.value;
                end else begin
                    res.kind = KIND_ERROR;
                    res.last = 1'b1;
                    done     = 1'b1;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_step      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act  <= 1'b1;
                r_step <= 1'b0;
            end else if (produce) begin
                if (done) begin
                    r_act <= 1'b0;
                end else begin
                    r_step <= 1'b1;
                end
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end else if (produce && !done && r_cmd.op == OP_RUN) begin
            r_cmd.addr  <= r_cmd.addr + 16'd1;
            r_cmd.count <= r_cmd.count - CNT_W'(1);
        end
        if (produce) begin
            r_res <= res;
        end
    end

endmodule

// ----- src/sprite_rle_decoder.sv -----
// Top level of the sprite run-length decoder.
// Takes one encoded sprite byte per word: a four-byte header (width, height, x and y
// offset), then per row a run count and its run specs (skip, literal copy or fill).
// It returns header reports, linear pixel writes at row*width+column, sprite-end words
// and bounds errors; after an error or a completed sprite the next byte starts a new
// header. The front end accepts one byte per cycle while its four-entry command queue
// has room, and each byte leaves at most one command. The back end loads a command only
// when it has none in hand and then emits its result words, holding while the output
// register is full and not taken: a literal byte or a header gives a single word (a
// literal that reports a bounds error adds an error word), and a fill run one word per
// pixel; sustained throughput is set by that back-end expansion loop. An output
// register lets the front keep accepting while a finished word waits to be taken.
module sprite_rle_decoder #(
    parameter int LENGTH_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_pixel_address,
    output logic [7:0]  o_pixel_value,
    output logic [7:0]  o_sprite_width,
    output logic [7:0]  o_sprite_height,
    output logic [7:0]  o_offset_x,
    output logic [7:0]  o_offset_y,
    output logic        o_sprite_end,
    output logic        o_last
);
    import srd_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_cmd    push_cmd;
    t_cmd    pop_cmd;
    t_result res;

    srd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    srd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_empty    (q_empty)
    );

    srd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .i_cmd       (pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_kind          = res.kind;
    assign o_pixel_address = res.pixel_address;
    assign o_pixel_value   = res.pixel_value;
    assign o_sprite_width  = res.sprite_width;
    assign o_sprite_height = res.sprite_height;
    assign o_offset_x      = res.offset_x;
    assign o_offset_y      = res.offset_y;
    assign o_sprite_end    = res.sprite_end;
    assign o_last          = res.last;

endmodule

// ----- src/srd_checker.sv -----
// Port-level checker for the sprite decoder and its bind.
`include "sprite_rle_decoder_defines.svh"

module srd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [15:0] o_pixel_address,
    input logic [7:0]  o_pixel_value,
    input logic [7:0]  o_sprite_width,
    input logic [7:0]  o_sprite_height,
    input logic [7:0]  o_offset_x,
    input logic [7:0]  o_offset_y,
    input logic        o_sprite_end,
    input logic        o_last
);
    import srd_pkg::*;

    logic        out_stall;
    logic        out_error;
    logic        out_nonpixel;
    logic        out_nonheader;
    logic        pix_zero;
    logic        hdr_zero;
    logic [59:0] out_word;

    assign out_stall     = o_out_valid && !i_out_ready;
    assign out_error     = o_out_valid && (o_kind == KIND_ERROR);
    assign out_nonpixel  = o_out_valid && (o_kind != KIND_PIXEL);
    assign out_nonheader = o_out_valid && (o_kind != KIND_HEADER);
    assign pix_zero      = (o_pixel_address == 16'd0) && (o_pixel_value == 8'd0);
    assign hdr_zero      = (o_sprite_width == 8'd0) && (o_sprite_height == 8'd0) &&
                           (o_offset_x == 8'd0) && (o_offset_y == 8'd0);
    assign out_word      = {o_kind, o_pixel_address, o_pixel_value, o_sprite_width,
                            o_sprite_height, o_offset_x, o_offset_y, o_sprite_end, o_last};

    // a stalled word holds
    `SRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word))

    `SRD_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_sprite_end, o_last)

    // errors close the byte's words and never complete a sprite
    `SRD_ASSERT_NOW(a_error_last, i_clk, i_rst_n, out_error, o_last && !o_sprite_end)

    `SRD_ASSERT_NOW(a_nonpixel_zero, i_clk, i_rst_n, out_nonpixel, pix_zero)

    `SRD_ASSERT_NOW(a_header_fields, i_clk, i_rst_n, out_nonheader, hdr_zero)

endmodule

bind sprite_rle_decoder srd_checker u_checker (.*);
